### rtl/fpdc_pkg.sv
// ----------------------------------------------------------------------------
// Fractional PLL divider calculation package
// Widths, constants, status codes and register indexes shared by the
// divider calculation and its checker.
// ----------------------------------------------------------------------------
package fpdc_pkg;

	localparam int TARGET_W    = 32;
	localparam int CRYSTAL_W   = 26;
	localparam int DEN_W       = CRYSTAL_W + 1;
	localparam int VCO_W       = TARGET_W + 1;
	localparam int IQ_W        = 8;
	localparam int SEL_W       = 3;
	localparam int N_W         = 6;
	localparam int S_W         = 2;
	localparam int SDM_W       = 16;
	localparam int ST_W        = 2;
	localparam int CFG_IDX_W   = 1;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int MAX_DIV_SEL_DEF = 5;

	localparam logic [63:0] VCO_MIN_HZ = 64'd1770000000;
	localparam logic [IQ_W-1:0] MULT_LOW  = IQ_W'(13);
	localparam logic [IQ_W-1:0] MULT_HIGH = IQ_W'(13 + 128);

	localparam logic [CRYSTAL_W-1:0] CRYSTAL_RST = CRYSTAL_W'(32000000);
	localparam logic                 REF_DIRECT_RST = 1'b1;

	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_LOW  = 2'd1;
	localparam logic [ST_W-1:0] ST_HIGH = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_CRYSTAL    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REF_DIRECT = 1'd1;

	// Smallest target that reaches the VCO minimum with divider code sel.
	function automatic logic [TARGET_W-1:0] fpdc_vco_thr(input int sel);
		logic [63:0] step;
		step = 64'd1 << (sel + 1);
		return TARGET_W'((VCO_MIN_HZ + step - 64'd1) >> (sel + 1));
	endfunction

endpackage

### rtl/fractional_pll_divider_calc.sv
// ----------------------------------------------------------------------------
// Fractional PLL divider calculation
// Turns a requested frequency into output divider, integer divider and
// sigma-delta fraction settings through a fully pipelined datapath.
// ----------------------------------------------------------------------------
// The block accepts one request transaction per clock cycle while in_stall
// is low and returns one result transaction per request, in order. The
// request and divider code stages select the output divider and range check
// the multiplier, then a restoring divider produces one quotient bit per
// pipeline stage over 8 + FRAC_BITS + 1 stages, and a final stage rounds,
// snaps the fraction and registers the result. Stalls close up empty stages,
// so a stalled result does not block new requests while the pipeline still
// has room. The divider reads the crystal settings at every stage, so
// configuration must only be written while no transaction is in flight.
module fractional_pll_divider_calc
	import fpdc_pkg::*;
#(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int MAX_DIV_SEL = MAX_DIV_SEL_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CRYSTAL_W-1:0]  cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [TARGET_W-1:0]   target_hz,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [ST_W-1:0]       status,
	output logic                  refdiv_bit,
	output logic [SEL_W-1:0]      out_div_sel,
	output logic [N_W-1:0]        int_div_n,
	output logic [S_W-1:0]        int_div_s,
	output logic                  sdm_off,
	output logic [SDM_W-1:0]      sdm_fraction
);

	localparam int QW = IQ_W + FRAC_BITS + 1;
	localparam int PW = DEN_W + IQ_W;
	localparam int FR_M_I = 1 << (FRAC_BITS - 7);
	localparam int FR_HALF_I = 1 << (FRAC_BITS - 1);
	localparam logic [FRAC_BITS-1:0] FR_M     = FRAC_BITS'(FR_M_I);
	localparam logic [FRAC_BITS-1:0] FR_HALF  = FRAC_BITS'(FR_HALF_I);
	localparam logic [FRAC_BITS-1:0] FR_LOWER = FRAC_BITS'(FR_HALF_I - FR_M_I / 2);
	localparam logic [FRAC_BITS-1:0] FR_UPPER = FRAC_BITS'(FR_HALF_I + FR_M_I / 2);
	localparam logic [FRAC_BITS-1:0] FR_TOP   = FRAC_BITS'((1 << FRAC_BITS) - FR_M_I);

	logic [CRYSTAL_W-1:0] crystal_q;
	logic                 ref_direct_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crystal_q    <= CRYSTAL_RST;
			ref_direct_q <= REF_DIRECT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CRYSTAL:    crystal_q    <= cfg_data;
				CFG_REF_DIRECT: ref_direct_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic en_s1, en_s2, en_out;
	logic en_d [QW+1];

	// Stage 1: request register.
	logic                v_s1;
	logic [TARGET_W-1:0] target_s1;

	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			target_s1 <= target_hz;
		end
	end

	logic [SEL_W-1:0] sel_c;
	logic             low_c;
	logic [VCO_W-1:0] vco_c;

	always_comb begin
		sel_c = '0;
		low_c = 1'b1;
		for (int s = MAX_DIV_SEL; s >= 0; s--) begin
			if (target_s1 >= fpdc_vco_thr(s)) begin
				sel_c = SEL_W'(s);
				low_c = 1'b0;
			end
		end
		vco_c = VCO_W'({32'd0, target_s1} << ({1'b0, sel_c} + 4'd1));
	end

	// Stage 2: divider code and VCO frequency.
	logic             v_s2;
	logic [VCO_W-1:0] vco_s2;
	logic [SEL_W-1:0] sel_s2;
	logic             low_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			vco_s2 <= vco_c;
			sel_s2 <= sel_c;
			low_s2 <= low_c;
		end
	end

	logic [DEN_W-1:0] den;
	logic [PW-1:0]    lim_lo, lim_hi;
	logic [ST_W-1:0]  st_c;

	assign den    = ref_direct_q ? {1'b0, crystal_q} : {crystal_q, 1'b0};
	assign lim_lo = PW'(den) * PW'(MULT_LOW);
	assign lim_hi = PW'(den) * PW'(MULT_HIGH);

	always_comb begin
		if (low_s2) begin
			st_c = ST_LOW;
		end else if (den == '0) begin
			st_c = ST_HIGH;
		end else if (PW'(vco_s2) < lim_lo) begin
			st_c = ST_LOW;
		end else if (PW'(vco_s2) >= lim_hi) begin
			st_c = ST_HIGH;
		end else begin
			st_c = ST_OK;
		end
	end

	// Stage 3 onwards: restoring divider, one quotient bit per stage.
	logic                dv_v_s3   [QW+1];
	logic [DEN_W-1:0]    dv_rem_s3 [QW+1];
	logic [IQ_W-1:0]     dv_low_s3 [QW+1];
	logic [QW-1:0]       dv_q_s3   [QW+1];
	logic [ST_W-1:0]     dv_st_s3  [QW+1];
	logic [SEL_W-1:0]    dv_sel_s3 [QW+1];
	logic                dv_ref_s3 [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s3[0] <= 1'b0;
		end else if (en_d[0]) begin
			dv_v_s3[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_d[0] && v_s2) begin
			dv_rem_s3[0] <= DEN_W'(vco_s2 >> IQ_W);
			dv_low_s3[0] <= vco_s2[IQ_W-1:0];
			dv_q_s3[0]   <= '0;
			dv_st_s3[0]  <= st_c;
			dv_sel_s3[0] <= sel_s2;
			dv_ref_s3[0] <= ref_direct_q;
		end
	end

	assign en_s1 = !v_s1 || en_s2;
	assign en_s2 = !v_s2 || en_d[0];
	assign en_d[QW] = !dv_v_s3[QW] || en_out;

	for (genvar k = 1; k <= QW; k++) begin : g_div
		logic [DEN_W:0]   trial;
		logic             ge;
		logic [DEN_W-1:0] rem_nx;

		assign en_d[k-1] = !dv_v_s3[k-1] || en_d[k];
		assign trial  = {dv_rem_s3[k-1], dv_low_s3[k-1][IQ_W-1]};
		assign ge     = trial >= {1'b0, den};
		assign rem_nx = ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s3[k] <= 1'b0;
			end else if (en_d[k]) begin
				dv_v_s3[k] <= dv_v_s3[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en_d[k] && dv_v_s3[k-1]) begin
				dv_rem_s3[k] <= rem_nx;
				dv_low_s3[k] <= {dv_low_s3[k-1][IQ_W-2:0], 1'b0};
				dv_q_s3[k]   <= {dv_q_s3[k-1][QW-2:0], ge};
				dv_st_s3[k]  <= dv_st_s3[k-1];
				dv_sel_s3[k] <= dv_sel_s3[k-1];
				dv_ref_s3[k] <= dv_ref_s3[k-1];
			end
		end
	end

	// Rounding and boundary-spur snapping.
	logic [QW:0]          rnd;
	logic [QW-1:0]        scaled;
	logic [FRAC_BITS-1:0] frac, frac_sn;
	logic [IQ_W:0]        mint, mint_sn, mint_off;

	assign rnd    = {1'b0, dv_q_s3[QW]} + (QW+1)'(1);
	assign scaled = rnd[QW:1];
	assign frac   = scaled[FRAC_BITS-1:0];
	assign mint   = scaled[QW-1:FRAC_BITS];

	always_comb begin
		frac_sn = frac;
		mint_sn = mint;
		if (frac < FR_M) begin
			frac_sn = '0;
		end else if (frac > FR_TOP) begin
			mint_sn = mint + (IQ_W+1)'(1);
			frac_sn = '0;
		end else if (frac < FR_HALF && frac > FR_LOWER) begin
			frac_sn = FR_LOWER;
		end else if (frac > FR_HALF && frac < FR_UPPER) begin
			frac_sn = FR_UPPER;
		end
		mint_off = mint_sn - (IQ_W+1)'(MULT_LOW);
	end

	// Output register.
	logic                out_v_q;
	logic [ST_W-1:0]     status_q;
	logic                refdiv_q;
	logic [SEL_W-1:0]    div_sel_q;
	logic [N_W-1:0]      n_q;
	logic [S_W-1:0]      s_q;
	logic                sdm_off_q;
	logic [SDM_W-1:0]    frac_q;
	logic                ok;

	assign en_out = !out_v_q || !out_stall;
	assign ok     = dv_st_s3[QW] == ST_OK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_out) begin
			out_v_q <= dv_v_s3[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && dv_v_s3[QW]) begin
			status_q  <= dv_st_s3[QW];
			refdiv_q  <= dv_ref_s3[QW];
			div_sel_q <= ok ? dv_sel_s3[QW] : '0;
			n_q       <= ok ? mint_off[N_W+1:2] : '0;
			s_q       <= ok ? mint_off[1:0] : '0;
			sdm_off_q <= ok ? (frac_sn == '0) : 1'b0;
			frac_q    <= ok ? SDM_W'(frac_sn) : '0;
		end
	end

	assign out_valid    = out_v_q;
	assign status       = status_q;
	assign refdiv_bit   = refdiv_q;
	assign out_div_sel  = div_sel_q;
	assign int_div_n    = n_q;
	assign int_div_s    = s_q;
	assign sdm_off      = sdm_off_q;
	assign sdm_fraction = frac_q;

endmodule

### rtl/fpdc_checker.sv
// ----------------------------------------------------------------------------
// Fractional PLL divider calculation checker
// Port-level assertions on result transactions, bound to the top level.
// ----------------------------------------------------------------------------
module fpdc_checker
	import fpdc_pkg::*;
#(
	parameter int MAX_DIV_SEL = MAX_DIV_SEL_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [ST_W-1:0]      status,
	input logic [SEL_W-1:0]     out_div_sel,
	input logic [N_W-1:0]       int_div_n,
	input logic [S_W-1:0]       int_div_s,
	input logic                 sdm_off,
	input logic [SDM_W-1:0]     sdm_fraction
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(sdm_fraction))
		else $error("Stalled result transaction changed or vanished.");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> out_div_sel == '0 && int_div_n == '0 &&
			int_div_s == '0 && !sdm_off && sdm_fraction == '0)
		else $error("Rejected request carries non-zero divider settings.");

	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> out_div_sel <= SEL_W'(MAX_DIV_SEL))
		else $error("Output divider code beyond the largest divider.");

	a_int_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> int_div_n <= N_W'(32))
		else $error("Integer divider beyond the multiplier range.");

endmodule

bind fractional_pll_divider_calc fpdc_checker #(.MAX_DIV_SEL(MAX_DIV_SEL)) u_fpdc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.out_div_sel  (out_div_sel),
	.int_div_n    (int_div_n),
	.int_div_s    (int_div_s),
	.sdm_off      (sdm_off),
	.sdm_fraction (sdm_fraction)
);
